>>> design/cfi_pkg.sv
`default_nettype none
package cfi_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 49;
	localparam int DIR_STEPS  = 17;
	localparam int REM_W      = 33;
	localparam int NUM_W      = 49;
	localparam int LEN_W      = 33;

	typedef struct packed {
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] point_vel_x;
		logic signed [31:0] point_vel_y;
		logic signed [31:0] point_vel_z;
		logic signed [31:0] normal_impulse;
		logic signed [31:0] denominator;
		logic [17:0]        static_friction;
		logic [17:0]        dynamic_friction;
	} req_t;

	typedef struct packed {
		logic signed [31:0] impulse_x;
		logic signed [31:0] impulse_y;
		logic signed [31:0] impulse_z;
		logic               sticking;
		logic               saturated;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] ni;
		logic signed [31:0] den;
		logic [17:0]        sf;
		logic [17:0]        df;
	} side_t;

	typedef struct packed {
		logic [63:0]      x;
		logic [63:0]      res;
		logic [2:0][31:0] tmag;
		logic [2:0]       tneg;
		side_t            side;
	} sqrt_t;

	typedef struct packed {
		logic [NUM_W-1:0]           num_r;
		logic [REM_W-1:0]           rem_r;
		logic [NUM_W-1:0]           quo_r;
		logic [2:0][DIR_STEPS-1:0]  num_u;
		logic [2:0][REM_W-1:0]      rem_u;
		logic [2:0][DIR_STEPS-1:0]  quo_u;
		logic [LEN_W-1:0]           len;
		logic [2:0]                 tneg;
		logic                       zero;
		side_t                      side;
	} div_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] a);
		logic [31:0] m;
		m = a;
		return a[31] ? (~m + 32'd1) : m;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [51:0] v);
		if (v > 52'sd2147483647) return 32'sh7fffffff;
		if (v < -52'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// one restoring division step: returns {quotient bit, new remainder}
	function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
			input logic b, input logic [REM_W-1:0] dv);
		logic [REM_W+1:0] diff;
		logic             ge;
		diff = {1'b0, rem, b} - {2'b00, dv};
		ge = !diff[REM_W+1];
		return ge ? {1'b1, diff[REM_W-1:0]} : {1'b0, rem[REM_W-2:0], b};
	endfunction

	function automatic div_t to_div(input sqrt_t s);
		div_t d;
		d.len   = s.res[LEN_W-1:0];
		d.num_r = {s.res[LEN_W-1:0], 16'h0000};
		d.rem_r = '0;
		d.quo_r = '0;
		for (int i = 0; i < 3; i++) begin
			d.num_u[i] = {s.tmag[i][0], 16'h0000};
			d.rem_u[i] = {2'b00, s.tmag[i][31:1]};
			d.quo_u[i] = '0;
		end
		d.tneg = s.tneg;
		d.zero = (s.res == 64'd0) || (s.side.den <= 32'sd0);
		d.side = s.side;
		return d;
	endfunction

endpackage
`default_nettype wire

>>> design/cfi_if.sv
`default_nettype none
interface cfi_req_if;
	logic           valid;
	logic           ready;
	cfi_pkg::req_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cfi_rsp_if;
	logic           valid;
	logic           ready;
	cfi_pkg::rsp_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/cfi_front.sv
`default_nettype none
module cfi_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  cfi_pkg::req_t      in_data,
	output logic               out_valid,
	output cfi_pkg::sqrt_t     out_data
);

	logic [5:0] vld_q;

	logic signed [31:0] v_s1 [3], n_s1 [3];
	logic [63:0]        p_s1 [3];
	logic [2:0]         ps_s1;
	cfi_pkg::side_t     side_s1;

	logic signed [31:0] v_s2 [3], n_s2 [3];
	logic signed [31:0] d_s2;
	cfi_pkg::side_t     side_s2;

	logic signed [31:0] v_s3 [3];
	logic [63:0]        q_s3 [3];
	logic [2:0]         qs_s3;
	cfi_pkg::side_t     side_s3;

	logic [31:0]        tm_s4 [3];
	logic [2:0]         tn_s4;
	cfi_pkg::side_t     side_s4;

	logic [63:0]        sq_s5 [3];
	logic [31:0]        tm_s5 [3];
	logic [2:0]         tn_s5;
	cfi_pkg::side_t     side_s5;

	logic signed [31:0] vin [3], nin [3];
	logic signed [49:0] term [3];
	logic signed [51:0] dsum;
	logic signed [49:0] qterm [3];
	logic signed [51:0] tdiff [3];
	logic signed [31:0] tcl [3];

	always_comb begin
		vin[0] = in_data.point_vel_x;
		vin[1] = in_data.point_vel_y;
		vin[2] = in_data.point_vel_z;
		nin[0] = in_data.normal_x;
		nin[1] = in_data.normal_y;
		nin[2] = in_data.normal_z;
		for (int i = 0; i < 3; i++) begin
			term[i] = ps_s1[i] ? -$signed({2'b00, p_s1[i][63:16]})
				: $signed({2'b00, p_s1[i][63:16]});
			qterm[i] = qs_s3[i] ? -$signed({2'b00, q_s3[i][63:16]})
				: $signed({2'b00, q_s3[i][63:16]});
			tdiff[i] = {{20{v_s3[i][31]}}, v_s3[i]} - {{2{qterm[i][49]}}, qterm[i]};
			tcl[i] = cfi_pkg::clamp32(tdiff[i]);
		end
		dsum = {{2{term[0][49]}}, term[0]} + {{2{term[1][49]}}, term[1]}
			+ {{2{term[2][49]}}, term[2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[i]  <= vin[i];
				n_s1[i]  <= nin[i];
				p_s1[i]  <= cfi_pkg::mag32(vin[i]) * cfi_pkg::mag32(nin[i]);
				ps_s1[i] <= vin[i][31] ^ nin[i][31];

				v_s2[i] <= v_s1[i];
				n_s2[i] <= n_s1[i];

				v_s3[i]  <= v_s2[i];
				q_s3[i]  <= cfi_pkg::mag32(d_s2) * cfi_pkg::mag32(n_s2[i]);
				qs_s3[i] <= d_s2[31] ^ n_s2[i][31];

				tm_s4[i] <= cfi_pkg::mag32(tcl[i]);
				tn_s4[i] <= tcl[i][31];

				sq_s5[i] <= tm_s4[i] * tm_s4[i];
				tm_s5[i] <= tm_s4[i];
				tn_s5[i] <= tn_s4[i];
			end
			side_s1.ni  <= in_data.normal_impulse;
			side_s1.den <= in_data.denominator;
			side_s1.sf  <= in_data.static_friction;
			side_s1.df  <= in_data.dynamic_friction;
			d_s2    <= cfi_pkg::clamp32(dsum);
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			// three squares of at most 2^62 each cannot overflow 64 bits
			out_data.x   <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			out_data.res <= '0;
			for (int i = 0; i < 3; i++) begin
				out_data.tmag[i] <= tm_s5[i];
			end
			out_data.tneg <= tn_s5;
			out_data.side <= side_s5;
		end
	end

	assign out_valid = vld_q[5];

endmodule
`default_nettype wire

>>> design/cfi_sqrt_cell.sv
`default_nettype none
module cfi_sqrt_cell #(
	parameter int J = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  cfi_pkg::sqrt_t     in_data,
	output logic               out_valid,
	output cfi_pkg::sqrt_t     out_data
);

	localparam logic [63:0] BIT = 64'h1 << (62 - 2 * J);

	logic           vld_q;
	cfi_pkg::sqrt_t d_q;
	cfi_pkg::sqrt_t nxt;
	logic [63:0]    rb;

	always_comb begin
		nxt = in_data;
		rb  = in_data.res + BIT;
		if (in_data.x >= rb) begin
			nxt.x   = in_data.x - rb;
			nxt.res = (in_data.res >> 1) + BIT;
		end else begin
			nxt.res = in_data.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_valid = vld_q;
	assign out_data  = d_q;

endmodule
`default_nettype wire

>>> design/cfi_div_cell.sv
`default_nettype none
module cfi_div_cell #(
	parameter int J = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  cfi_pkg::div_t      in_data,
	output logic               out_valid,
	output cfi_pkg::div_t      out_data
);

	localparam int RB = cfi_pkg::NUM_W - 1 - J;

	logic                       vld_q;
	cfi_pkg::div_t              d_q;
	cfi_pkg::div_t              nxt;
	logic [cfi_pkg::REM_W:0]    step_r;

	always_comb begin
		nxt = in_data;
		step_r = cfi_pkg::div_step(in_data.rem_r, in_data.num_r[RB],
			{1'b0, in_data.side.den});
		nxt.rem_r = step_r[cfi_pkg::REM_W-1:0];
		nxt.quo_r = {in_data.quo_r[cfi_pkg::NUM_W-2:0], step_r[cfi_pkg::REM_W]};
	end

	// direction lanes only run in the last steps, their quotient is narrow
	generate
		if (J >= cfi_pkg::DIV_STEPS - cfi_pkg::DIR_STEPS) begin : g_dir
			localparam int UB = cfi_pkg::DIV_STEPS - 1 - J;
			cfi_pkg::div_t              nxt_u;
			logic [cfi_pkg::REM_W:0]    step_u [3];
			always_comb begin
				nxt_u = nxt;
				for (int i = 0; i < 3; i++) begin
					step_u[i] = cfi_pkg::div_step(in_data.rem_u[i], in_data.num_u[i][UB],
						in_data.len);
					nxt_u.rem_u[i] = step_u[i][cfi_pkg::REM_W-1:0];
					nxt_u.quo_u[i] = {in_data.quo_u[i][cfi_pkg::DIR_STEPS-2:0],
						step_u[i][cfi_pkg::REM_W]};
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					d_q <= nxt_u;
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					d_q <= nxt;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	assign out_valid = vld_q;
	assign out_data  = d_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !d_q.zero |-> d_q.rem_r < {1'b0, d_q.side.den})
		else $error("rate remainder not below denominator");

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !d_q.zero |-> d_q.rem_u[0] < d_q.len)
		else $error("direction remainder not below length");

endmodule
`default_nettype wire

>>> design/cfi_back.sv
`default_nettype none
module cfi_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  cfi_pkg::div_t      in_data,
	output logic               out_valid,
	output cfi_pkg::rsp_t      out_data
);

	logic [3:0] vld_q;

	logic [49:0]                     lp_s1, dp_s1;
	logic                            nin_s1;
	logic [cfi_pkg::NUM_W-1:0]       rev_s1;
	logic [2:0][cfi_pkg::DIR_STEPS-1:0] u_s1;
	logic [2:0]                      tn_s1;
	logic                            z_s1;

	logic [46:0]                     fm_s2;
	logic                            fn_s2;
	logic                            st_s2;
	logic [2:0][cfi_pkg::DIR_STEPS-1:0] u_s2;
	logic [2:0]                      tn_s2;
	logic                            z_s2;

	logic [63:0]                     m_s3 [3];
	logic                            fn_s3;
	logic                            st_s3;
	logic [2:0]                      tn_s3;
	logic                            z_s3;

	logic signed [35:0] lim, dyn;
	logic signed [50:0] revs, lims, dyns, f, fc, fa;
	logic               stick;
	logic signed [48:0] r [3];
	logic signed [31:0] rc [3];
	logic [2:0]         hit;

	always_comb begin
		lim = nin_s1 ? -$signed({2'b00, lp_s1[49:16]}) : $signed({2'b00, lp_s1[49:16]});
		dyn = nin_s1 ? -$signed({2'b00, dp_s1[49:16]}) : $signed({2'b00, dp_s1[49:16]});
		revs  = $signed({2'b00, rev_s1});
		lims  = {{15{lim[35]}}, lim};
		dyns  = {{15{dyn[35]}}, dyn};
		stick = revs < lims;
		f = stick ? revs : dyns;
		if (f > 51'sh400000000000) begin
			fc = 51'sh400000000000;
		end else if (f < -51'sh400000000000) begin
			fc = -51'sh400000000000;
		end else begin
			fc = f;
		end
		fa = fc[50] ? -fc : fc;
		for (int i = 0; i < 3; i++) begin
			// impulse opposes the tangential velocity when the magnitude is positive
			r[i] = (tn_s3[i] ^ fn_s3) ? $signed({1'b0, m_s3[i][63:16]})
				: -$signed({1'b0, m_s3[i][63:16]});
			rc[i]  = cfi_pkg::clamp32({{3{r[i][48]}}, r[i]});
			hit[i] = ({{3{r[i][48]}}, r[i]} != {{20{rc[i][31]}}, rc[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lp_s1  <= in_data.side.sf * cfi_pkg::mag32(in_data.side.ni);
			dp_s1  <= in_data.side.df * cfi_pkg::mag32(in_data.side.ni);
			nin_s1 <= in_data.side.ni[31];
			rev_s1 <= in_data.quo_r;
			u_s1   <= in_data.quo_u;
			tn_s1  <= in_data.tneg;
			z_s1   <= in_data.zero;

			fm_s2 <= fa[46:0];
			fn_s2 <= fc[50];
			st_s2 <= stick;
			u_s2  <= u_s1;
			tn_s2 <= tn_s1;
			z_s2  <= z_s1;

			for (int i = 0; i < 3; i++) begin
				m_s3[i] <= u_s2[i] * fm_s2;
			end
			fn_s3 <= fn_s2;
			st_s3 <= st_s2;
			tn_s3 <= tn_s2;
			z_s3  <= z_s2;

			if (z_s3) begin
				out_data <= '0;
			end else begin
				out_data.impulse_x <= rc[0];
				out_data.impulse_y <= rc[1];
				out_data.impulse_z <= rc[2];
				out_data.sticking  <= st_s3;
				out_data.saturated <= |hit;
			end
		end
	end

	assign out_valid = vld_q[3];

endmodule
`default_nettype wire

>>> design/coulomb_friction_impulse_top.sv
// channel  modport  payload          direction
// req      sink     cfi_pkg::req_t   contact in
// rsp      source   cfi_pkg::rsp_t   friction impulse out
//
// one request per cycle while no result waits on rsp; request to result passes 6 front stages
// (dot product, tangent, squares), 32 square root cells, 49 divider cells, 4 back stages
// the divider chain sets the depth: one quotient bit per cell for the 49-bit rate
// reset clears only the valid bits, no flush pass
// the whole chain holds while a result waits on rsp; req.ready follows that
`default_nettype none
module coulomb_friction_impulse_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	cfi_req_if.sink         req,
	cfi_rsp_if.source       rsp
);

	logic en;

	logic                   sq_v [cfi_pkg::SQRT_STEPS+1];
	cfi_pkg::sqrt_t         sq_d [cfi_pkg::SQRT_STEPS+1];
	logic                   dv_v [cfi_pkg::DIV_STEPS+1];
	cfi_pkg::div_t          dv_d [cfi_pkg::DIV_STEPS+1];

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	cfi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req.valid),
		.in_data   (req.data),
		.out_valid (sq_v[0]),
		.out_data  (sq_d[0])
	);

	genvar g;
	generate
		for (g = 0; g < cfi_pkg::SQRT_STEPS; g++) begin : g_sqrt
			cfi_sqrt_cell #(.J(g)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (sq_v[g]),
				.in_data   (sq_d[g]),
				.out_valid (sq_v[g+1]),
				.out_data  (sq_d[g+1])
			);
		end
	endgenerate

	assign dv_v[0] = sq_v[cfi_pkg::SQRT_STEPS];
	assign dv_d[0] = cfi_pkg::to_div(sq_d[cfi_pkg::SQRT_STEPS]);

	generate
		for (g = 0; g < cfi_pkg::DIV_STEPS; g++) begin : g_div
			cfi_div_cell #(.J(g)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (dv_v[g]),
				.in_data   (dv_d[g]),
				.out_valid (dv_v[g+1]),
				.out_data  (dv_d[g+1])
			);
		end
	endgenerate

	cfi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_v[cfi_pkg::DIV_STEPS]),
		.in_data   (dv_d[cfi_pkg::DIV_STEPS]),
		.out_valid (rsp.valid),
		.out_data  (rsp.data)
	);

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.saturated |->
			rsp.data.impulse_x == 32'sh7fffffff || rsp.data.impulse_x == 32'sh80000000 ||
			rsp.data.impulse_y == 32'sh7fffffff || rsp.data.impulse_y == 32'sh80000000 ||
			rsp.data.impulse_z == 32'sh7fffffff || rsp.data.impulse_z == 32'sh80000000)
		else $error("saturated flag without a clipped component");

endmodule
`default_nettype wire
